// ===== sv/llsf_pkg.sv =====
`timescale 1ns / 1ps

// Shared constants and types for the least-squares line fit core.
package llsf_pkg;

	// Default point memory depth
	localparam int MAX_POINTS_DEF = 1024;

	// Point coordinate width (signed Q8.8)
	localparam int COORD_W = 16;

	// Start fraction register, units of 1/256
	localparam int FRAC_W = 8;
	localparam logic [FRAC_W-1:0] FRAC_RESET = 8'd51;

	// Result width (signed Q16.16) and numerator scalings
	localparam int Q_W     = 32;
	localparam int A_SHIFT = 8;
	localparam int B_SHIFT = 16;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_SAT      = 2'd2;
	localparam logic [1:0] ST_DROPPED  = 2'd3;

	// One memory word: a stored point
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// Divider result, valid while done is high
	typedef struct packed {
		logic                  done;
		logic                  sat;
		logic signed [Q_W-1:0] quo;
	} div_res_t;

endpackage

// ===== sv/llsf_if.sv =====
`timescale 1ns / 1ps

// Point channel: one word per point
interface llsf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [llsf_pkg::COORD_W-1:0]  x_value;
	logic signed [llsf_pkg::COORD_W-1:0]  y_value;
	logic                                 is_last;

	modport source (output valid, x_value, y_value, is_last, input ready);
	modport sink   (input valid, x_value, y_value, is_last, output ready);
endinterface

// Result channel: one word per fitted set
interface llsf_out_if #(
	parameter int CNT_W = $clog2(llsf_pkg::MAX_POINTS_DEF + 1)
);
	logic                             valid;
	logic                             ready;
	logic signed [llsf_pkg::Q_W-1:0]  intercept;
	logic signed [llsf_pkg::Q_W-1:0]  slope;
	logic [CNT_W-1:0]                 points_used;
	logic [1:0]                       status;

	modport source (output valid, intercept, slope, points_used, status, input ready);
	modport sink   (input valid, intercept, slope, points_used, status, output ready);
endinterface

// ===== sv/llsf_point_mem.sv =====
`timescale 1ns / 1ps

// Point memory: one write port, one registered read port.
module llsf_point_mem #(
	parameter int DEPTH = llsf_pkg::MAX_POINTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  llsf_pkg::point_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output llsf_pkg::point_t rdata
);

	llsf_pkg::point_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/llsf_mul.sv =====
`timescale 1ns / 1ps

// Shift-add signed multiplier, one operand bit per cycle.
// done pulses for one cycle with prod valid.
module llsf_mul #(
	parameter int W = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic                  done,
	output logic signed [2*W-1:0] prod
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]   ma_q;
	logic [2*W-1:0] mb_q;
	logic [2*W-1:0] acc_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           fin_q;

	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	assign mag_a = a[W-1] ? (~a + W'(1)) : a;
	assign mag_b = b[W-1] ? (~b + W'(1)) : b;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath: add shifted multiplicand per set bit
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag_a;
			mb_q  <= {{W{1'b0}}, mag_b};
			acc_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (busy_q) begin
			if (ma_q[0]) begin
				acc_q <= acc_q + mb_q;
			end
			ma_q <= ma_q >> 1;
			mb_q <= mb_q << 1;
		end
	end

	assign done = fin_q;
	assign prod = neg_q ? signed'(~acc_q + (2*W)'(1)) : signed'(acc_q);

endmodule

// ===== sv/llsf_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Quotient is saturated to the signed Q_W range.
module llsf_div #(
	parameter int NUM_W = 101,
	parameter int DEN_W = 52
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic                 neg,
	input  logic [DEN_W-1:0]     den,
	output llsf_pkg::div_res_t   res
);

	localparam int QW = llsf_pkg::Q_W;
	localparam int CW = $clog2(NUM_W + 1);
	localparam logic [QW:0] POS_LIM = {2'b00, {(QW-1){1'b1}}};
	localparam logic [QW:0] NEG_LIM = {2'b01, {(QW-1){1'b0}}};

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW:0]      q_q;
	logic             big_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             fin_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;
	logic           sat;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath: bits that fall off the quotient top mark an overflow
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			q_q   <= '0;
			big_q <= 1'b0;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			q_q   <= {q_q[QW-1:0], ge};
			big_q <= big_q | q_q[QW];
			num_q <= num_q << 1;
		end
	end

	// saturate and apply sign
	assign sat = big_q || (q_q > (neg_q ? NEG_LIM : POS_LIM));

	always_comb begin
		res.done = fin_q;
		res.sat  = sat;
		if (sat) begin
			res.quo = neg_q ? signed'({1'b1, {(QW-1){1'b0}}})
			                : signed'({1'b0, {(QW-1){1'b1}}});
		end else if (neg_q) begin
			res.quo = signed'(~q_q[QW-1:0] + QW'(1));
		end else begin
			res.quo = signed'(q_q[QW-1:0]);
		end
	end

endmodule

// ===== sv/linear_least_squares_fit_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Word                                   Accepted when
// points    in   x_value, y_value (Q8.8), is_last       points.valid & points.ready
// result    out  intercept, slope (Q16.16),             result.valid & result.ready
//                points_used, status
// cfg       in   start_fraction (8 bit)                 cfg_we high
//
// Points load at one per cycle into the point memory. A word with is_last set
// starts a fit and points are not taken until it ends; a zero denominator skips both
// quotients. A finished result sits in the output register; loading continues while
// it waits. arst_n clears counters and control; memory contents stay undefined.
module linear_least_squares_fit_core #(
	parameter int MAX_POINTS = llsf_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [llsf_pkg::FRAC_W-1:0] cfg_wdata,
	llsf_in_if.sink                     points,
	llsf_out_if.source                  result
);

	localparam int CW     = llsf_pkg::COORD_W;
	localparam int FW     = llsf_pkg::FRAC_W;
	localparam int QW     = llsf_pkg::Q_W;
	localparam int AW     = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SX_W   = CW + 1 + AW;
	localparam int SX2_W  = 2*CW - 1 + AW;
	localparam int SXY_W  = 2*CW + AW;
	localparam int MUL_W  = SXY_W;
	localparam int PROD_W = 2*MUL_W;
	localparam int DEN_W  = CNT_W + SX2_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int NUMS_W = NUM_W + llsf_pkg::B_SHIFT;
	localparam int SA     = llsf_pkg::A_SHIFT;
	localparam int SB     = llsf_pkg::B_SHIFT;

	typedef enum logic [8:0] {
		S_LOAD  = 9'b000000001,
		S_START = 9'b000000010,
		S_ACC   = 9'b000000100,
		S_MUL   = 9'b000001000,
		S_DIFF  = 9'b000010000,
		S_CHECK = 9'b000100000,
		S_DIVA  = 9'b001000000,
		S_DIVB  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	// product schedule
	typedef enum logic [2:0] {
		P_MSX2  = 3'd0,
		P_SXSX  = 3'd1,
		P_SX2SY = 3'd2,
		P_SXSXY = 3'd3,
		P_MSXY  = 3'd4,
		P_SXSY  = 3'd5
	} prod_sel_t;

	state_t    state_q;
	prod_sel_t op_q;

	logic [FW-1:0]    frac_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [CNT_W-1:0] n_q;
	logic             ovf_fit_q;
	logic [CNT_W-1:0] m_q;
	logic [CNT_W-1:0] idx_q;
	logic             v_s1;
	logic             v_s2;
	logic             mul_run_q;
	logic             div_run_q;
	logic             out_v_q;

	// accumulate pipeline and sums
	logic signed [CW-1:0]    x_s2;
	logic signed [CW-1:0]    y_s2;
	logic signed [2*CW-1:0]  xx_s2;
	logic signed [2*CW-1:0]  xy_s2;
	logic signed [SX_W-1:0]  sx_q;
	logic signed [SX_W-1:0]  sy_q;
	logic [SX2_W-1:0]        sx2_q;
	logic signed [SXY_W-1:0] sxy_q;

	logic signed [PROD_W-1:0] prod_q [6];
	logic [DEN_W-1:0]         den_q;
	logic signed [NUM_W-1:0]  na_q;
	logic signed [NUM_W-1:0]  nb_q;
	logic                     zero_q;
	logic signed [QW-1:0]     a_q;
	logic signed [QW-1:0]     b_q;
	logic                     sat_a_q;
	logic                     sat_b_q;

	logic signed [QW-1:0] int_q;
	logic signed [QW-1:0] slope_q;
	logic [CNT_W-1:0]     used_q;
	logic [1:0]           status_q;

	// handshakes
	logic in_acc;
	logic out_take;
	logic has_room;
	logic out_load;

	assign points.ready = (state_q == S_LOAD);
	assign in_acc       = points.valid && points.ready;
	assign out_take     = result.valid && result.ready;
	assign has_room     = cnt_q < CNT_W'(MAX_POINTS);
	assign out_load     = (state_q == S_DONE) && (!out_v_q || result.ready);

	// start index: floor(n * fraction / 256)
	logic [CNT_W+FW-1:0] st_prod;
	logic [CNT_W-1:0]    st_idx;

	assign st_prod = (CNT_W+FW)'(n_q) * (CNT_W+FW)'(frac_q);
	assign st_idx  = st_prod[CNT_W+FW-1:FW];

	// point memory
	llsf_pkg::point_t wr_pt;
	llsf_pkg::point_t rd_pt;
	logic             rd_en;

	assign wr_pt.x = points.x_value;
	assign wr_pt.y = points.y_value;
	assign rd_en   = (state_q == S_ACC) && (idx_q < n_q);

	llsf_point_mem #(
		.DEPTH (MAX_POINTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (in_acc && has_room),
		.waddr (cnt_q[AW-1:0]),
		.wdata (wr_pt),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_pt)
	);

	// multiplier operand select
	logic signed [MUL_W-1:0] m_ext;
	logic signed [MUL_W-1:0] sx_ext;
	logic signed [MUL_W-1:0] sy_ext;
	logic signed [MUL_W-1:0] sx2_ext;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic                    mul_start;
	logic                    mul_done;
	logic signed [PROD_W-1:0] mul_prod;

	assign m_ext   = signed'({{(MUL_W-CNT_W){1'b0}}, m_q});
	assign sx_ext  = signed'({{(MUL_W-SX_W){sx_q[SX_W-1]}}, sx_q});
	assign sy_ext  = signed'({{(MUL_W-SX_W){sy_q[SX_W-1]}}, sy_q});
	assign sx2_ext = signed'({{(MUL_W-SX2_W){1'b0}}, sx2_q});

	always_comb begin
		case (op_q)
			P_MSX2:  begin mul_a = m_ext;   mul_b = sx2_ext; end
			P_SXSX:  begin mul_a = sx_ext;  mul_b = sx_ext;  end
			P_SX2SY: begin mul_a = sx2_ext; mul_b = sy_ext;  end
			P_SXSXY: begin mul_a = sx_ext;  mul_b = sxy_q;   end
			P_MSXY:  begin mul_a = m_ext;   mul_b = sxy_q;   end
			P_SXSY:  begin mul_a = sx_ext;  mul_b = sy_ext;  end
			default: begin mul_a = '0;      mul_b = '0;      end
		endcase
	end

	assign mul_start = (state_q == S_MUL) && !mul_run_q;

	llsf_mul #(
		.W (MUL_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// divider numerator: magnitude, scaled for a Q16.16 quotient
	logic                    sel_b;
	logic signed [NUM_W-1:0] num_sel;
	logic                    num_neg;
	logic [NUM_W-1:0]        num_mag;
	logic [NUMS_W-1:0]       num_scaled;
	logic                    div_start;
	llsf_pkg::div_res_t      div_res;

	assign sel_b      = (state_q == S_DIVB);
	assign num_sel    = sel_b ? nb_q : na_q;
	assign num_neg    = num_sel[NUM_W-1];
	assign num_mag    = num_neg ? (~num_sel + NUM_W'(1)) : num_sel;
	assign num_scaled = sel_b ? {num_mag, {SB{1'b0}}}
	                          : {{(SB-SA){1'b0}}, num_mag, {SA{1'b0}}};
	assign div_start  = (state_q == S_DIVA || state_q == S_DIVB) && !div_run_q;

	llsf_div #(
		.NUM_W (NUMS_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_scaled),
		.neg    (num_neg),
		.den    (den_q),
		.res    (div_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			op_q      <= P_MSX2;
			frac_q    <= llsf_pkg::FRAC_RESET;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			ovf_fit_q <= 1'b0;
			idx_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			mul_run_q <= 1'b0;
			div_run_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frac_q <= cfg_wdata;
			end
			// output word valid
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
			v_s1 <= rd_en;
			v_s2 <= v_s1;

			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (points.is_last) begin
							n_q       <= has_room ? cnt_q + CNT_W'(1) : cnt_q;
							ovf_fit_q <= ovf_q || !has_room;
							cnt_q     <= '0;
							ovf_q     <= 1'b0;
							state_q   <= S_START;
						end else if (has_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_START: begin
					idx_q   <= st_idx;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!v_s1 && !v_s2) begin
						op_q    <= P_MSX2;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!mul_run_q) begin
						mul_run_q <= 1'b1;
					end else if (mul_done) begin
						mul_run_q <= 1'b0;
						if (op_q == P_SXSY) begin
							state_q <= S_DIFF;
						end else begin
							op_q <= prod_sel_t'(op_q + 3'd1);
						end
					end
				end
				S_DIFF: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= (den_q == '0) ? S_DONE : S_DIVA;
				end
				S_DIVA: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_res.done) begin
						div_run_q <= 1'b0;
						state_q   <= S_DIVB;
					end
				end
				S_DIVB: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_res.done) begin
						div_run_q <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// products of the point read in the previous cycle
		if (v_s1) begin
			x_s2  <= rd_pt.x;
			y_s2  <= rd_pt.y;
			xx_s2 <= rd_pt.x * rd_pt.x;
			xy_s2 <= rd_pt.x * rd_pt.y;
		end

		// running sums
		if (state_q == S_START) begin
			m_q   <= n_q - st_idx;
			sx_q  <= '0;
			sy_q  <= '0;
			sx2_q <= '0;
			sxy_q <= '0;
		end else if (v_s2) begin
			sx_q  <= sx_q + signed'({{(SX_W-CW){x_s2[CW-1]}}, x_s2});
			sy_q  <= sy_q + signed'({{(SX_W-CW){y_s2[CW-1]}}, y_s2});
			sx2_q <= sx2_q + {{(SX2_W-2*CW){1'b0}}, xx_s2};
			sxy_q <= sxy_q + signed'({{(SXY_W-2*CW){xy_s2[2*CW-1]}}, xy_s2});
		end

		if (state_q == S_MUL && mul_run_q && mul_done) begin
			prod_q[op_q] <= mul_prod;
		end

		// denominator and both numerators
		if (state_q == S_DIFF) begin
			den_q <= DEN_W'(prod_q[P_MSX2] - prod_q[P_SXSX]);
			na_q  <= signed'({prod_q[P_SX2SY][PROD_W-1], prod_q[P_SX2SY]})
			       - signed'({prod_q[P_SXSXY][PROD_W-1], prod_q[P_SXSXY]});
			nb_q  <= signed'({prod_q[P_MSXY][PROD_W-1], prod_q[P_MSXY]})
			       - signed'({prod_q[P_SXSY][PROD_W-1], prod_q[P_SXSY]});
		end

		if (state_q == S_CHECK) begin
			zero_q  <= (den_q == '0);
			a_q     <= '0;
			b_q     <= '0;
			sat_a_q <= 1'b0;
			sat_b_q <= 1'b0;
		end
		if (state_q == S_DIVA && div_run_q && div_res.done) begin
			a_q     <= div_res.quo;
			sat_a_q <= div_res.sat;
		end
		if (state_q == S_DIVB && div_run_q && div_res.done) begin
			b_q     <= div_res.quo;
			sat_b_q <= div_res.sat;
		end

		// output register
		if (out_load) begin
			int_q   <= a_q;
			slope_q <= b_q;
			used_q  <= m_q;
			if (zero_q) begin
				status_q <= llsf_pkg::ST_ZERO_DEN;
			end else if (sat_a_q || sat_b_q) begin
				status_q <= llsf_pkg::ST_SAT;
			end else if (ovf_fit_q) begin
				status_q <= llsf_pkg::ST_DROPPED;
			end else begin
				status_q <= llsf_pkg::ST_OK;
			end
		end
	end

	assign result.valid       = out_v_q;
	assign result.intercept   = int_q;
	assign result.slope       = slope_q;
	assign result.points_used = used_q;
	assign result.status      = status_q;

endmodule

// ===== tb/sv/linear_least_squares_fit_core_tb.sv =====
`timescale 1ns / 1ps

module linear_least_squares_fit_core_tb;
	import llsf_pkg::*;

	localparam int PT_DEPTH = MAX_POINTS_DEF;
	localparam int CNT_W    = $clog2(PT_DEPTH + 1);

	typedef enum logic [1:0] {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
	} point_word_t;

	typedef struct {
		logic signed [Q_W-1:0] intercept;
		logic signed [Q_W-1:0] slope;
		logic [CNT_W-1:0]      points_used;
		logic [1:0]            status;
	} line_fit_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [FRAC_W-1:0] cfg_wdata;

	llsf_in_if  pts();
	llsf_out_if fit();

	linear_least_squares_fit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.points   (pts),
		.result   (fit)
	);

	// stimulus and scoreboard state
	point_word_t pending[$];
	line_fit_t   fits_due[$];
	gap_mode_t   gap_mode = GAP_NONE;
	int          errors = 0;

	// shadow of the point memory and the start fraction
	logic signed [COORD_W-1:0] x_mem [PT_DEPTH];
	logic signed [COORD_W-1:0] y_mem [PT_DEPTH];
	int unsigned               stored = 0;
	logic                      dropped = 1'b0;
	logic [FRAC_W-1:0]         start_frac = FRAC_RESET;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// exact quotient, truncated toward zero, clamped to 32 bits
	function automatic logic [Q_W-1:0] quotient_q16(input logic signed [127:0] num,
			input logic [127:0] den, output logic clipped);
		logic         neg;
		logic [127:0] mag;
		logic [127:0] q;
		neg = num[127];
		mag = neg ? 128'(-num) : 128'(num);
		q = mag / den;
		clipped = 1'b0;
		if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
			clipped = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? -q[Q_W-1:0] : q[Q_W-1:0];
	endfunction

	// least-squares line over the stored points past the skipped lead-in
	function automatic line_fit_t fit_stored();
		int unsigned         skip;
		int unsigned         used;
		int unsigned         i;
		longint              sx, sy, sx2, sxy, den;
		logic signed [127:0] w_sx, w_sy, w_sx2, w_sxy, w_m, num_a, num_b;
		logic                clip_a, clip_b;
		line_fit_t           f;
		skip = (stored * start_frac) >> 8;
		used = stored - skip;
		sx = 0;
		sy = 0;
		sx2 = 0;
		sxy = 0;
		for (i = skip; i < stored; i++) begin
			sx  += longint'(x_mem[i]);
			sy  += longint'(y_mem[i]);
			sx2 += longint'(x_mem[i]) * longint'(x_mem[i]);
			sxy += longint'(x_mem[i]) * longint'(y_mem[i]);
		end
		den = longint'(used) * sx2 - sx * sx;
		f.points_used = used[CNT_W-1:0];
		if (den == 0) begin
			f.intercept = '0;
			f.slope = '0;
			f.status = ST_ZERO_DEN;
			return f;
		end
		w_sx = sx;
		w_sy = sy;
		w_sx2 = sx2;
		w_sxy = sxy;
		w_m = used;
		num_a = (w_sx2 * w_sy - w_sx * w_sxy) <<< A_SHIFT;
		num_b = (w_m * w_sxy - w_sx * w_sy) <<< B_SHIFT;
		f.intercept = quotient_q16(num_a, 128'(den), clip_a);
		f.slope = quotient_q16(num_b, 128'(den), clip_b);
		f.status = (clip_a || clip_b) ? ST_SAT : (dropped ? ST_DROPPED : ST_OK);
		return f;
	endfunction

	// one accepted point word; a full memory drops it
	function automatic void take_point(input logic signed [COORD_W-1:0] xv,
			input logic signed [COORD_W-1:0] yv, input logic last);
		if (stored < PT_DEPTH) begin
			x_mem[stored] = xv;
			y_mem[stored] = yv;
			stored++;
		end else begin
			dropped = 1'b1;
		end
		if (last) begin
			fits_due.push_back(fit_stored());
			stored = 0;
			dropped = 1'b0;
		end
	endfunction

	function automatic logic send_gap();
		case (gap_mode)
			GAP_SEND: return $urandom_range(99) < 49;
			GAP_BOTH: return $urandom_range(99) < 37;
			default:  return 1'b0;
		endcase
	endfunction

	function automatic logic recv_stall();
		case (gap_mode)
			GAP_RECV: return $urandom_range(99) < 49;
			GAP_BOTH: return $urandom_range(99) < 37;
			default:  return 1'b0;
		endcase
	endfunction

	function automatic void compare_field(input string field, input logic [Q_W-1:0] want,
			input logic [Q_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
		end
	endfunction

	function automatic void check_fit(input line_fit_t got);
		line_fit_t want;
		if (fits_due.size() == 0) begin
			errors++;
			$display("%0t result word with none expected: expected none, actual %h %h %0d %0d",
				$time, got.intercept, got.slope, got.points_used, got.status);
			return;
		end
		want = fits_due.pop_front();
		compare_field("intercept", want.intercept, got.intercept);
		compare_field("slope", want.slope, got.slope);
		compare_field("points_used", Q_W'(want.points_used), Q_W'(got.points_used));
		compare_field("status", Q_W'(want.status), Q_W'(got.status));
	endfunction

	// point driver: feeds pending words, records each accepted word
	always @(posedge clk or negedge arst_n) begin : drive_points
		point_word_t word;
		if (!arst_n) begin
			pts.valid <= 1'b0;
			pts.x_value <= '0;
			pts.y_value <= '0;
			pts.is_last <= 1'b0;
		end else begin
			if (pts.valid && pts.ready)
				take_point(pts.x_value, pts.y_value, pts.is_last);
			if (!pts.valid || pts.ready) begin
				if (pending.size() != 0 && !send_gap()) begin
					word = pending.pop_front();
					pts.valid <= 1'b1;
					pts.x_value <= word.x;
					pts.y_value <= word.y;
					pts.is_last <= word.last;
				end else begin
					pts.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin : watch_results
		line_fit_t got;
		if (!arst_n) begin
			fit.ready <= 1'b0;
		end else begin
			if (fit.valid && fit.ready) begin
				got.intercept = fit.intercept;
				got.slope = fit.slope;
				got.points_used = fit.points_used;
				got.status = fit.status;
				check_fit(got);
			end
			fit.ready <= !recv_stall();
		end
	end

	function automatic void queue_point(input logic [COORD_W-1:0] xv,
			input logic [COORD_W-1:0] yv, input logic last);
		point_word_t word;
		word.x = xv;
		word.y = yv;
		word.last = last;
		pending.push_back(word);
	endfunction

	// one set of random shape; returns its size
	function automatic int queue_random_set();
		int unsigned          n, shape, pick, k;
		logic [COORD_W-1:0]   base, xv, yv;
		pick = $urandom_range(99);
		n = pick < 5 ? 1 : (pick < 12 ? 2 : $urandom_range(14, 3));
		shape = $urandom_range(9);
		base = COORD_W'($urandom_range(65535));
		for (k = 0; k < n; k++) begin
			yv = COORD_W'($urandom_range(65535));
			case (shape)
				5, 6: begin
					xv = COORD_W'($urandom_range(1024)) - 16'd512;
					yv = COORD_W'($urandom_range(1024)) - 16'd512;
				end
				7: xv = base;                                  // vertical line
				8: xv = base + COORD_W'($urandom_range(1));    // steep, may clip
				default: xv = COORD_W'($urandom_range(65535));
			endcase
			queue_point(xv, yv, k == n - 1);
		end
		return n;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || pts.valid || fits_due.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_fraction(input logic [FRAC_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		start_frac = value;
	endtask

	initial begin : stimulus
		int unsigned k, phase, count;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed sets at the reset fraction
		@(negedge clk);
		queue_point(16'h8000, 16'h7FFF, 1'b1);          // single point
		queue_point(16'd100, 16'd5, 1'b0);              // equal abscissas
		queue_point(16'd100, -16'd7, 1'b1);
		queue_point(16'd0, 16'h8000, 1'b0);             // slope clips high
		queue_point(16'd1, 16'h7FFF, 1'b1);
		queue_point(16'd0, 16'h7FFF, 1'b0);             // slope clips low
		queue_point(16'd1, 16'h8000, 1'b1);
		queue_point(16'h8000, 16'h8000, 1'b0);          // full-range diagonal
		queue_point(16'h7FFF, 16'h7FFF, 1'b1);
		queue_point(16'h7FFF, 16'h8000, 1'b0);
		queue_point(16'h8000, 16'h7FFF, 1'b0);
		queue_point(16'hFFFF, 16'h0000, 1'b0);
		queue_point(16'h0000, 16'hFFFF, 1'b1);
		for (k = 0; k < 6; k++)                         // six points: one skipped
			queue_point(COORD_W'($urandom), COORD_W'($urandom), k == 5);
		wait_drained();

		// whole memory fitted, then overflow drops the tail and the marked word
		set_fraction('0);
		@(negedge clk);
		for (k = 0; k < PT_DEPTH + 6; k++)
			queue_point(COORD_W'($urandom), COORD_W'($urandom), k == PT_DEPTH + 5);
		count = 0;
		while (count < 40)
			count += queue_random_set();
		wait_drained();

		// random sets over every gap pattern and several fractions
		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       set_fraction(8'd255);
				2:       set_fraction(8'd128);
				4:       set_fraction(8'd1);
				default: set_fraction(FRAC_W'($urandom_range(255)));
			endcase
			@(negedge clk);
			gap_mode = gap_mode_t'((phase + 1) % 4);
			count = 0;
			while (count < 100)
				count += queue_random_set();
			wait_drained();
		end

		gap_mode = GAP_NONE;
		repeat (1600) @(negedge clk);
		if (errors == 0)
			$display("linear_least_squares_fit_core verification clean");
		else
			$display("linear_least_squares_fit_core verification failed");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("linear_least_squares_fit_core verification failed");
		$finish;
	end

endmodule
